@@ hw/rtl/refcount_registry_hash_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the refcount registry
// Shared forms for the concurrent checks of the registry ports.
// ----------------------------------------------------------------------------
`ifndef REFCOUNT_REGISTRY_HASH_TABLE_CORE_DEFINES_SVH
`define REFCOUNT_REGISTRY_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define RCHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define RCHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/rcht_pkg.sv @@
// ----------------------------------------------------------------------------
// rcht_pkg
// Types, codes and constants of the refcount registry hash table.
// ----------------------------------------------------------------------------
package rcht_pkg;

	localparam int unsigned DEF_SLOTS     = 1024;
	localparam int unsigned DEF_ADDR_BITS = 48;

	localparam int unsigned CNT_W = 32;
	localparam logic signed [CNT_W-1:0] CNT_MAX = 32'sh7FFF_FFFF;

	// Hash: low 48 bits of (address >> 3) times the golden-ratio constant
	localparam int unsigned HASH_W     = 48;
	localparam int unsigned HASH_HALF  = HASH_W / 2;
	localparam int unsigned HASH_SHIFT = 32;
	localparam logic [HASH_HALF-1:0] HASH_MUL_LO = 24'h4A7C15;
	localparam logic [HASH_HALF-1:0] HASH_MUL_HI = 24'h79B97F;
	localparam logic [1:0] HASH_LAST_STEP = 2'd3;

	localparam int unsigned REQ_W = 3;
	localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_RETAIN   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RELEASE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_IMMORTAL = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd4;

	localparam int unsigned STATUS_W = 3;
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RESERVED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_LIVE = 3'd4;

	// Write enables of the slot memory
	typedef struct packed {
		logic key;
		logic cnt;
	} rcht_wen_t;

endpackage

@@ hw/rtl/rcht_req_if.sv @@
// ----------------------------------------------------------------------------
// rcht_req_if
// Request channel: request type and object address, valid/ready.
// ----------------------------------------------------------------------------
interface rcht_req_if import rcht_pkg::*; #(
	parameter int unsigned ADDR_W = DEF_ADDR_BITS
) ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output req_type, output address, input ready);
	modport sink   (input valid, input req_type, input address, output ready);
endinterface

@@ hw/rtl/rcht_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rcht_rsp_if
// Response channel: status, hit, count, zero flag and live total, valid/ready.
// ----------------------------------------------------------------------------
interface rcht_rsp_if import rcht_pkg::*; #(
	parameter int unsigned LIVE_W = $clog2(DEF_SLOTS) + 1
) ();
	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic                    hit;
	logic signed [CNT_W-1:0] count_after;
	logic                    reached_zero;
	logic [LIVE_W-1:0]       live_entries;

	modport source (output valid, output status, output hit, output count_after,
		output reached_zero, output live_entries, input ready);
	modport sink (input valid, input status, input hit, input count_after,
		input reached_zero, input live_entries, output ready);
endinterface

@@ hw/rtl/rcht_hash.sv @@
// ----------------------------------------------------------------------------
// rcht_hash
// Home slot of a key: 48-bit product built from three 24x24 partial products.
// ----------------------------------------------------------------------------
module rcht_hash import rcht_pkg::*; #(
	parameter int unsigned IDX_W = $clog2(DEF_SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] key,
	output logic              done,
	output logic [IDX_W-1:0]  home
);

	logic [HASH_W-1:0]    key_q;
	logic [HASH_W-1:0]    acc_q;
	logic [1:0]           step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [HASH_W-1:0]    prod_s1;
	logic                 pv_s1;
	logic                 sh_s1;
	logic [HASH_HALF-1:0] op_a;
	logic [HASH_HALF-1:0] op_b;
	logic [HASH_W-1:0]    addend;

	// low*low, low*high, high*low; high*high falls off the top
	always_comb begin
		op_a = key_q[HASH_HALF-1:0];
		op_b = HASH_MUL_LO;
		unique case (step_q)
			2'd0: begin
				op_a = key_q[HASH_HALF-1:0];
				op_b = HASH_MUL_LO;
			end
			2'd1: begin
				op_a = key_q[HASH_HALF-1:0];
				op_b = HASH_MUL_HI;
			end
			default: begin
				op_a = key_q[HASH_W-1:HASH_HALF];
				op_b = HASH_MUL_LO;
			end
		endcase
	end

	assign addend = sh_s1 ? {prod_s1[HASH_HALF-1:0], {HASH_HALF{1'b0}}} : prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		sh_s1   <= (step_q != 2'd0);
		if (start) begin
			key_q <= key;
			acc_q <= '0;
		end else if (busy_q && pv_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == HASH_LAST_STEP);
			pv_s1  <= !start && busy_q && (step_q != HASH_LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == HASH_LAST_STEP) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign home = acc_q[HASH_SHIFT +: IDX_W];

endmodule

@@ hw/rtl/rcht_slot_mem.sv @@
// ----------------------------------------------------------------------------
// rcht_slot_mem
// Slot store: key array and count array, one write and one read port.
// ----------------------------------------------------------------------------
module rcht_slot_mem import rcht_pkg::*; #(
	parameter int unsigned SLOTS     = DEF_SLOTS,
	parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                          clk,
	input  rcht_wen_t                     wen,
	input  logic [$clog2(SLOTS)-1:0]      wr_idx,
	input  logic [ADDR_BITS-1:0]          wr_key,
	input  logic signed [CNT_W-1:0]       wr_cnt,
	input  logic                          rd_en,
	input  logic [$clog2(SLOTS)-1:0]      rd_idx,
	output logic [ADDR_BITS-1:0]          rd_key,
	output logic signed [CNT_W-1:0]       rd_cnt
);

	logic [ADDR_BITS-1:0]    keys [SLOTS];
	logic signed [CNT_W-1:0] cnts [SLOTS];

	always_ff @(posedge clk) begin
		if (wen.key) begin
			keys[wr_idx] <= wr_key;
		end
		if (wen.cnt) begin
			cnts[wr_idx] <= wr_cnt;
		end
		if (rd_en) begin
			rd_key <= keys[rd_idx];
			rd_cnt <= cnts[rd_idx];
		end
	end

endmodule

@@ hw/rtl/refcount_registry_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// refcount_registry_hash_table_core
// Registry of live object addresses with a signed reference count per entry,
// kept in an open-addressing table with linear probing and tombstones.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+----------
//  req     | in  | req_type, address                                | valid/ready
//  rsp     | out | status, hit, count_after, reached_zero,          | valid/ready
//          |     | live_entries                                     |
//
// A request passes an accept step, the hash unit (three partial
// products through one 24x24 multiplier), probing of the chain (one key
// memory read per cycle, read data registered), then a finish step that
// updates the slot and loads the response register.
// Reserved addresses and unknown types skip hash and probe.
// After reset the key memory is swept to empty, one slot a cycle, with
// req.ready low. A stalled response holds only the final update step.
// ----------------------------------------------------------------------------
module refcount_registry_hash_table_core import rcht_pkg::*; #(
	parameter int unsigned SLOTS     = DEF_SLOTS,
	parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
	input logic         clk,
	input logic         arst_n,
	rcht_req_if.sink    req,
	rcht_rsp_if.source  rsp
);

	localparam int unsigned IDX_W  = $clog2(SLOTS);
	localparam int unsigned LIVE_W = IDX_W + 1;
	localparam int unsigned CHK_W  = IDX_W + 4;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
	localparam logic [CHK_W-1:0] FULL_LIM = CHK_W'(SLOTS * 3);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_HASH   = 5'b00100,
		S_PROBE  = 5'b01000,
		S_FINISH = 5'b10000
	} rcht_state_t;

	rcht_state_t st_q;

	// request under work
	logic [REQ_W-1:0]     req_q;
	logic [ADDR_BITS-1:0] addr_q;

	// probe
	logic [IDX_W-1:0] clr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic             dv_s1;
	logic [IDX_W-1:0] n_q;
	logic             ff_vld_q;
	logic [IDX_W-1:0] ff_idx_q;

	// probe outcome
	logic                    hit_q;
	logic [IDX_W-1:0]        slot_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic                    free_vld_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic                    free_empty_q;

	// occupancy
	logic [LIVE_W-1:0] used_q;
	logic [LIVE_W-1:0] live_q;

	// response register
	logic                    rsp_vld_q;
	logic [STATUS_W-1:0]     rsp_status_q;
	logic                    rsp_hit_q;
	logic signed [CNT_W-1:0] rsp_cnt_q;
	logic                    rsp_zero_q;
	logic [LIVE_W-1:0]       rsp_live_q;

	// memory ports
	rcht_wen_t               wen;
	logic [IDX_W-1:0]        wr_idx;
	logic [ADDR_BITS-1:0]    wr_key;
	logic signed [CNT_W-1:0] wr_cnt;
	logic                    rd_en;
	logic [ADDR_BITS-1:0]    rd_key;
	logic signed [CNT_W-1:0] rd_cnt;

	// hash
	logic [HASH_W+ADDR_BITS-1:0] addr_ext;
	logic                        hash_start;
	logic                        hash_done;
	logic [IDX_W-1:0]            home;

	logic accept;
	logic skip;
	logic key_empty;
	logic key_match;
	logic key_tomb;
	logic probe_last;
	logic stop;
	logic fire;

	// finish step
	logic [STATUS_W-1:0]     fin_status;
	logic signed [CNT_W-1:0] fin_cnt;
	logic                    fin_zero;
	logic                    live_inc;
	logic                    live_dec;
	logic                    used_inc;
	logic [CHK_W-1:0]        used_chk;
	logic                    unknown_q;
	logic                    reserved_q;

	assign req.ready = (st_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign skip      = (req.req_type > REQ_REMOVE) || (req.address[ADDR_BITS-1:1] == '0);

	// hash the address with its three low bits dropped
	assign addr_ext   = {{HASH_W{1'b0}}, req.address};
	assign hash_start = accept && !skip;

	rcht_hash #(
		.IDX_W (IDX_W)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (addr_ext[3 +: HASH_W]),
		.done   (hash_done),
		.home   (home)
	);

	// classify the key just read from the slot memory
	assign key_empty  = (rd_key == '0);
	assign key_match  = (rd_key == addr_q);
	assign key_tomb   = (rd_key == ADDR_BITS'(1));
	assign probe_last = (n_q == IDX_LAST);
	assign stop       = dv_s1 && (key_empty || key_match || probe_last);
	assign rd_en      = (st_q == S_PROBE);

	assign fire       = (st_q == S_FINISH) && (!rsp_vld_q || rsp.ready);
	assign unknown_q  = (req_q > REQ_REMOVE);
	assign reserved_q = (addr_q[ADDR_BITS-1:1] == '0);
	assign used_chk   = ({3'b000, used_q} + CHK_W'(1)) << 2;

	// work out the response and the write-back for the request in hand
	always_comb begin
		fin_status = ST_OK;
		fin_cnt    = '0;
		fin_zero   = 1'b0;
		live_inc   = 1'b0;
		live_dec   = 1'b0;
		used_inc   = 1'b0;
		wen        = '0;
		wr_idx     = hit_q ? slot_q : free_idx_q;
		wr_key     = addr_q;
		wr_cnt     = cnt_q;
		priority if (unknown_q) begin
			fin_status = ST_OK;
		end else if (reserved_q) begin
			fin_status = ST_RESERVED;
		end else if (!hit_q) begin
			priority if (req_q != REQ_INSERT) begin
				fin_status = ST_NOT_FOUND;
			end else if (used_chk >= FULL_LIM || !free_vld_q) begin
				fin_status = ST_TABLE_FULL;
			end else begin
				// place the new key in the first free slot of its chain
				wen.key  = 1'b1;
				wen.cnt  = 1'b1;
				wr_cnt   = CNT_W'(1);
				fin_cnt  = CNT_W'(1);
				live_inc = 1'b1;
				used_inc = free_empty_q;
			end
		end else begin
			fin_cnt = cnt_q;
			unique case (req_q)
				REQ_INSERT: begin
					if (cnt_q == '0) begin
						fin_cnt  = CNT_W'(1);
						live_inc = 1'b1;
					end else begin
						fin_status = ST_ALREADY_LIVE;
					end
				end
				REQ_RETAIN: begin
					// immortal holds, saturate at the top
					if (!cnt_q[CNT_W-1] && cnt_q != CNT_MAX) begin
						fin_cnt  = cnt_q + CNT_W'(1);
						live_inc = (cnt_q == '0);
					end
				end
				REQ_RELEASE: begin
					if (!cnt_q[CNT_W-1] && cnt_q != '0) begin
						fin_cnt  = cnt_q - CNT_W'(1);
						fin_zero = (cnt_q == CNT_W'(1));
						live_dec = (cnt_q == CNT_W'(1));
					end
				end
				REQ_IMMORTAL: begin
					fin_cnt  = '1;
					live_inc = (cnt_q == '0);
				end
				default: begin
					// tombstone the slot, the count is left as it was
					fin_cnt  = '0;
					live_dec = (cnt_q != '0);
					wen.key  = 1'b1;
					wr_key   = ADDR_BITS'(1);
				end
			endcase
			if (req_q != REQ_REMOVE) begin
				wen.cnt = 1'b1;
				wr_cnt  = fin_cnt;
			end
		end
		// only the clearing sweep or a firing finish touches the memory
		if (st_q == S_CLEAR) begin
			wen     = '0;
			wen.key = 1'b1;
			wr_idx  = clr_idx_q;
			wr_key  = '0;
		end else if (!fire) begin
			wen = '0;
		end
	end

	rcht_slot_mem #(
		.SLOTS     (SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) u_mem (
		.clk    (clk),
		.wen    (wen),
		.wr_idx (wr_idx),
		.wr_key (wr_key),
		.wr_cnt (wr_cnt),
		.rd_en  (rd_en),
		.rd_idx (rd_idx_q),
		.rd_key (rd_key),
		.rd_cnt (rd_cnt)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLEAR;
			clr_idx_q <= '0;
			dv_s1     <= 1'b0;
			ff_vld_q  <= 1'b0;
			hit_q     <= 1'b0;
			used_q    <= '0;
			live_q    <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			// load a fresh response, else drop the one just taken
			if (fire) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (st_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_LAST) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						hit_q <= 1'b0;
						st_q  <= skip ? S_FINISH : S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						dv_s1    <= 1'b0;
						ff_vld_q <= 1'b0;
						st_q     <= S_PROBE;
					end
				end
				S_PROBE: begin
					dv_s1 <= !stop;
					if (dv_s1 && key_tomb && !ff_vld_q) begin
						ff_vld_q <= 1'b1;
					end
					if (stop) begin
						hit_q <= key_match;
						st_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fire) begin
						used_q <= used_q + LIVE_W'(used_inc);
						live_q <= live_q + LIVE_W'(live_inc) - LIVE_W'(live_dec);
						st_q   <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req.req_type;
			addr_q <= req.address;
		end
		if (st_q == S_HASH && hash_done) begin
			rd_idx_q <= home;
			n_q      <= '0;
		end
		if (st_q == S_PROBE) begin
			// advance the read pointer, wrapping round the table
			rd_idx_q <= rd_idx_q + IDX_W'(1);
			idx_s1   <= rd_idx_q;
			if (dv_s1) begin
				n_q <= n_q + IDX_W'(1);
				if (key_tomb && !ff_vld_q) begin
					ff_idx_q <= idx_s1;
				end
			end
			if (stop) begin
				slot_q       <= idx_s1;
				cnt_q        <= rd_cnt;
				free_vld_q   <= ff_vld_q || key_empty || key_tomb;
				free_idx_q   <= ff_vld_q ? ff_idx_q : idx_s1;
				free_empty_q <= !ff_vld_q && key_empty;
			end
		end
		if (fire) begin
			rsp_status_q <= fin_status;
			rsp_hit_q    <= hit_q && !unknown_q && !reserved_q;
			rsp_cnt_q    <= fin_cnt;
			rsp_zero_q   <= fin_zero;
			rsp_live_q   <= live_q + LIVE_W'(live_inc) - LIVE_W'(live_dec);
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.hit          = rsp_hit_q;
	assign rsp.count_after  = rsp_cnt_q;
	assign rsp.reached_zero = rsp_zero_q;
	assign rsp.live_entries = rsp_live_q;

endmodule

@@ hw/rtl/rcht_checker.sv @@
// ----------------------------------------------------------------------------
// rcht_checker
// Port-level checks of the refcount registry, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcount_registry_hash_table_core_defines.svh"

module rcht_checker import rcht_pkg::*; #(
	parameter int unsigned LIVE_W = $clog2(DEF_SLOTS) + 1
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic [STATUS_W-1:0]     rsp_status,
	input logic                    rsp_hit,
	input logic signed [CNT_W-1:0] rsp_count_after,
	input logic                    rsp_reached_zero,
	input logic [LIVE_W-1:0]       rsp_live_entries
);

	`RCHT_ASSERT_NEXT(a_rsp_hold_valid, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

	`RCHT_ASSERT_NEXT(a_rsp_hold_data, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_count_after) && $stable(rsp_live_entries), "response changed while stalled")

	`RCHT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while another is in work")

	`RCHT_ASSERT_SAME(a_hit_status, clk, arst_n, rsp_valid && rsp_hit, rsp_status == ST_OK || rsp_status == ST_ALREADY_LIVE, "hit with a miss status")

	`RCHT_ASSERT_SAME(a_zero_release, clk, arst_n, rsp_valid && rsp_reached_zero, rsp_hit && rsp_count_after == '0 && rsp_status == ST_OK, "zero flag without a release to zero")

endmodule

bind refcount_registry_hash_table_core rcht_checker #(
	.LIVE_W ($clog2(SLOTS) + 1)
) u_rcht_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_hit          (rsp.hit),
	.rsp_count_after  (rsp.count_after),
	.rsp_reached_zero (rsp.reached_zero),
	.rsp_live_entries (rsp.live_entries)
);

@@ tb/sv/registry_checker.sv @@
// ----------------------------------------------------------------------------
// registry_checker
// Watches the request and response channels of the refcount registry, keeps
// its own copy of the slot table and compares every response in order.
// ----------------------------------------------------------------------------
module registry_checker import rcht_pkg::*; #(
	parameter int unsigned SLOTS     = DEF_SLOTS,
	parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic clk,
	input  logic arst_n,
	rcht_req_if  req,
	rcht_rsp_if  rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDX_W  = $clog2(SLOTS);
	localparam int unsigned LIVE_W = IDX_W + 1;
	localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [ADDR_BITS-1:0] KEY_EMPTY = '0;
	localparam logic [ADDR_BITS-1:0] KEY_TOMB  = ADDR_BITS'(1);

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic                    hit;
		logic signed [CNT_W-1:0] count_after;
		logic                    reached_zero;
		logic [LIVE_W-1:0]       live_entries;
	} outcome_t;

	logic [ADDR_BITS-1:0] slot_key [SLOTS];
	int                   slot_cnt [SLOTS];
	int                   used_total;
	int                   live_total;
	outcome_t             outcomes_due[$];
	outcome_t             want;
	outcome_t             got;
	int                   err_cnt = 0;

	function automatic int home_of(input logic [ADDR_BITS-1:0] a);
		logic [63:0] prod;
		prod = 64'(a >> 3) * GOLDEN;
		return int'(prod[32 +: IDX_W]);
	endfunction

	// Slot holding a, or -1; the chain ends at the first empty slot
	function automatic int find_slot(input logic [ADDR_BITS-1:0] a);
		int i;
		i = home_of(a);
		for (int n = 0; n < SLOTS; n++) begin
			if (slot_key[i] == KEY_EMPTY)
				return -1;
			if (slot_key[i] == a)
				return i;
			i = (i + 1) % SLOTS;
		end
		return -1;
	endfunction

	function automatic int free_slot(input logic [ADDR_BITS-1:0] a);
		int i;
		i = home_of(a);
		for (int n = 0; n < SLOTS; n++) begin
			if (slot_key[i] <= KEY_TOMB)
				return i;
			i = (i + 1) % SLOTS;
		end
		return -1;
	endfunction

	task automatic apply_request(input logic [REQ_W-1:0] t, input logic [ADDR_BITS-1:0] a,
			output outcome_t o);
		int s;
		int f;
		int c;
		o = '0;
		if (t <= REQ_REMOVE && a <= KEY_TOMB) begin
			o.status = ST_RESERVED;
		end else if (t <= REQ_REMOVE) begin
			s = find_slot(a);
			if (s < 0) begin
				if (t != REQ_INSERT) begin
					o.status = ST_NOT_FOUND;
				end else if ((used_total + 1) * 4 >= SLOTS * 3) begin
					o.status = ST_TABLE_FULL;
				end else begin
					f = free_slot(a);
					if (f < 0) begin
						o.status = ST_TABLE_FULL;
					end else begin
						if (slot_key[f] == KEY_EMPTY)
							used_total++;
						slot_key[f] = a;
						slot_cnt[f] = 1;
						live_total++;
						o.count_after = 1;
					end
				end
			end else begin
				c = slot_cnt[s];
				o.hit = 1'b1;
				case (t)
					REQ_INSERT: begin
						if (c == 0) begin
							c = 1;
							live_total++;
						end else begin
							o.status = ST_ALREADY_LIVE;
						end
					end
					REQ_RETAIN: begin
						if (c >= 0 && c < CNT_MAX) begin
							if (c == 0)
								live_total++;
							c++;
						end
					end
					REQ_RELEASE: begin
						if (c > 0) begin
							c--;
							if (c == 0) begin
								o.reached_zero = 1'b1;
								live_total--;
							end
						end
					end
					REQ_IMMORTAL: begin
						if (c == 0)
							live_total++;
						c = -1;
					end
					default: begin
						if (c != 0)
							live_total--;
						slot_key[s] = KEY_TOMB;
						c = 0;
					end
				endcase
				if (t != REQ_REMOVE)
					slot_cnt[s] = c;
				o.count_after = c;
			end
		end
		o.live_entries = LIVE_W'(live_total);
	endtask

	task automatic report_mismatch(input string what, input longint seen, input longint wanted);
		$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, seen, wanted);
		err_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_key[i] = KEY_EMPTY;
				slot_cnt[i] = 0;
			end
			used_total = 0;
			live_total = 0;
			outcomes_due.delete();
			err_cnt = 0;
		end else begin
			// Responses first: a request accepted now cannot be answered on the same edge
			if (rsp.valid && rsp.ready) begin
				got.status       = rsp.status;
				got.hit          = rsp.hit;
				got.count_after  = rsp.count_after;
				got.reached_zero = rsp.reached_zero;
				got.live_entries = rsp.live_entries;
				if (outcomes_due.size() == 0) begin
					report_mismatch("unrequested response", 1, 0);
				end else begin
					want = outcomes_due.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.hit !== want.hit)
						report_mismatch("hit", got.hit, want.hit);
					if (got.count_after !== want.count_after)
						report_mismatch("count_after", longint'(got.count_after),
							longint'(want.count_after));
					if (got.reached_zero !== want.reached_zero)
						report_mismatch("reached_zero", got.reached_zero, want.reached_zero);
					if (got.live_entries !== want.live_entries)
						report_mismatch("live_entries", got.live_entries, want.live_entries);
				end
			end
			if (req.valid && req.ready) begin
				apply_request(req.req_type, req.address, want);
				outcomes_due.push_back(want);
			end
		end
		errors  <= err_cnt;
		pending <= outcomes_due.size();
	end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the refcount registry with random gaps and response
// stalls: a directed pass over every request kind and corner, then a random
// mix that fills the table towards its load limit. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rcht_pkg::*;

	localparam int unsigned AW           = DEF_ADDR_BITS;
	localparam int          RANDOM_ITEMS = 1400;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          IDLE_LIMIT   = 20000;
	localparam int          TAIL_CYCLES  = 60;
	localparam int          UNKNOWN_MAX  = (1 << REQ_W) - 1;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;

	// Pressure controls set by the main sequence for the sender and the receiver
	bit   hold_off  = 1'b0;
	bit   steady_tx = 1'b0;
	bit   steady_rx = 1'b0;

	rcht_req_if #(.ADDR_W(AW)) req ();
	rcht_rsp_if rsp ();

	refcount_registry_hash_table_core #(
		.SLOTS     (DEF_SLOTS),
		.ADDR_BITS (AW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	registry_checker #(
		.SLOTS     (DEF_SLOTS),
		.ADDR_BITS (AW)
	) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [AW-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[AW-1:0];
	endfunction

	// Offer one request from a falling edge, hold it until accepted, then
	// sometimes idle for a random gap; returns on a falling edge.
	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [AW-1:0] addr);
		int gap;
		req.valid    <= 1'b1;
		req.req_type <= kind;
		req.address  <= addr;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		gap = (steady_tx || $urandom_range(99) >= 35) ? 0 : gap_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Receiver: random stalls, a steady stretch, and one long hold-off
	// counted here while the sender keeps offering requests.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
				rsp.ready <= 1'b1;
			end else if (steady_rx) begin
				rsp.ready <= 1'b1;
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(99) < 25)
					stall_left = gap_len();
			end
		end
	end

	// Watchdog: give up when neither channel moves for too long. The limit
	// covers the key sweep after reset, the hold-off and the longest probe.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb_top failed");
		$finish;
	end

	initial begin
		logic [AW-1:0]    tracked[$];
		logic [AW-1:0]    addr;
		logic [AW-1:0]    key_a;
		logic [AW-1:0]    key_b;
		logic [REQ_W-1:0] kind;
		int               counted;
		int               k;
		int               roll;
		int               op;
		int               new_share;

		arst_n       = 1'b0;
		req.valid    <= 1'b0;
		req.req_type <= REQ_INSERT;
		req.address  <= '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed pass. key_b differs from key_a only below bit 3, so both
		// share a home slot and key_b lands in key_a's tombstone.
		key_a = AW'(64'h40);
		key_b = key_a | AW'(7);
		send_req(REQ_INSERT, '0);               // reserved address
		send_req(REQ_REMOVE, AW'(1));           // reserved address
		send_req(REQ_RETAIN, key_a);            // misses on an empty table
		send_req(REQ_RELEASE, key_a);
		send_req(REQ_IMMORTAL, key_a);
		send_req(REQ_REMOVE, key_a);
		send_req(REQ_INSERT, key_a);            // fresh entry
		send_req(REQ_INSERT, key_a);            // already live
		send_req(REQ_RETAIN, key_a);
		send_req(REQ_RELEASE, key_a);
		send_req(REQ_RELEASE, key_a);           // reaches zero, entry parked
		send_req(REQ_RELEASE, key_a);           // release of a parked entry
		send_req(REQ_INSERT, key_a);            // revive a parked entry
		send_req(REQ_RELEASE, key_a);
		send_req(REQ_RETAIN, key_a);            // retain revives too
		send_req(REQ_IMMORTAL, key_a);
		send_req(REQ_RETAIN, key_a);            // immortal stays put
		send_req(REQ_RELEASE, key_a);
		send_req(REQ_REMOVE, key_a);            // tombstone
		send_req(REQ_INSERT, key_b);            // reuse the tombstone
		send_req(REQ_INSERT, key_a);            // probe past key_b
		send_req(REQ_RELEASE, key_b);
		send_req(REQ_IMMORTAL, key_b);          // parked to immortal
		send_req(REQ_RELEASE, key_a);
		send_req(REQ_REMOVE, key_a);            // remove a parked entry
		send_req(REQ_INSERT, {AW{1'b1}});       // top address
		send_req(REQ_INSERT, AW'(2));           // lowest trackable address
		send_req(REQ_W'(REQ_REMOVE + 1), {AW{1'b1}});  // unknown request kinds
		send_req(REQ_W'(UNKNOWN_MAX), '0);
		tracked.push_back(key_b);
		tracked.push_back({AW{1'b1}});
		tracked.push_back(AW'(2));

		// Random pass: mostly well-formed traffic on tracked addresses, with
		// a heavy share of fresh inserts early on to drive the load to its
		// limit, plus misses, reserved addresses and unknown kinds as noise.
		counted = 0;
		k = 0;
		while (counted < RANDOM_ITEMS) begin
			if (k == 300) begin
				hold_off  = 1'b1;
				steady_tx = 1'b1;
			end
			if (k == 360)
				steady_tx = 1'b0;
			if (k == 700) begin
				// Drain: let every outstanding response come back
				req.valid <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			if (k == 900) begin
				steady_tx = 1'b1;
				steady_rx = 1'b1;
			end
			if (k == 1000) begin
				steady_tx = 1'b0;
				steady_rx = 1'b0;
			end

			roll = $urandom_range(99);
			new_share = (k < 1000) ? 75 : 25;
			if (roll < new_share) begin
				if ($urandom_range(3) == 0)
					addr = tracked[$urandom_range(tracked.size() - 1)] ^ AW'($urandom_range(7, 1));
				else
					addr = rand_addr();
				tracked.push_back(addr);
				kind = REQ_INSERT;
				counted++;
			end else if (roll < 94) begin
				addr = tracked[$urandom_range(tracked.size() - 1)];
				op = $urandom_range(99);
				if (op < 10)
					kind = REQ_INSERT;
				else if (op < 42)
					kind = REQ_RETAIN;
				else if (op < 78)
					kind = REQ_RELEASE;
				else if (op < 88)
					kind = REQ_IMMORTAL;
				else
					kind = REQ_REMOVE;
				counted++;
			end else if (roll < 97) begin
				addr = rand_addr();
				kind = REQ_W'($urandom_range(REQ_REMOVE, REQ_RETAIN));
				counted++;
			end else if (roll < 99) begin
				addr = AW'($urandom_range(1));
				kind = REQ_W'($urandom_range(REQ_REMOVE, REQ_INSERT));
			end else begin
				addr = rand_addr();
				kind = REQ_W'($urandom_range(UNKNOWN_MAX, REQ_REMOVE + 1));
			end
			send_req(kind, addr);
			k++;
		end
		req.valid <= 1'b0;

		// Drain, then watch a little longer for stray responses
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rcht_pkg.sv
hw/rtl/rcht_req_if.sv
hw/rtl/rcht_rsp_if.sv
hw/rtl/rcht_hash.sv
hw/rtl/rcht_slot_mem.sv
hw/rtl/refcount_registry_hash_table_core.sv
hw/rtl/rcht_checker.sv
tb/sv/registry_checker.sv
tb/sv/tb_top.sv
